@@ src/tke_pkg.sv @@
// Package for the Teager-Kaiser energy onset detector.
// Holds the sizes, register indexes and sequencer states; no dependencies.
`default_nettype none
package tke_pkg;
  localparam int WINDOW_LEN  = 64;
  localparam int OVERLAP_LEN = 32;
  localparam int CALIB_LEN   = 256;
  localparam int EFF_OVERLAP = (OVERLAP_LEN >= WINDOW_LEN) ? WINDOW_LEN - 1 : OVERLAP_LEN;

  localparam int SAMPLE_W = 12;
  localparam int SCALED_W = 15;
  localparam int ENERGY_W = 28;
  localparam int THR_W    = 32;
  localparam int K_W      = 8;
  localparam int HOLD_W   = 10;
  localparam int CFG_W    = 10;
  localparam int MUL_W    = 29;
  localparam int PROD_W   = 58;
  localparam int RPTR_W   = $clog2(WINDOW_LEN);
  localparam int FILL_W   = $clog2(WINDOW_LEN) + 1;
  localparam int CIDX_W   = $clog2(CALIB_LEN);
  localparam int WSUM_W   = ENERGY_W + RPTR_W;
  localparam int CSUM_W   = ENERGY_W + CIDX_W;
  localparam int SQ_W     = 2 * ENERGY_W + CIDX_W;
  localparam int VAR_W    = 2 * ENERGY_W;

  typedef enum logic [0:0] {
    REG_K_THRESHOLD = 1'b0,
    REG_HOLDOFF     = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DET_QUIET   = 2'd0,
    DET_ABOVE   = 2'd1,
    DET_RELEASE = 2'd2
  } detect_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MBB, S_MAC, S_ENERGY, S_UPDATE, S_SQ,
    S_SQRT, S_KMUL, S_THR, S_DETECT, S_DONE
  } state_t;
endpackage
`default_nettype wire

@@ src/tke_onset_detector_top.sv @@
// Top level of the Teager-Kaiser energy onset detector.
// Depends on tke_pkg; holds the sequencer, the shared multiplier and both memories.
// One item is taken at a time; s_tready is high only while the sequencer is idle. An ordinary
// item makes two passes through the single 29x29 multiplier for the energy, then forms its
// magnitude, updates the window and calibration, runs detection, loads the output register and
// returns to idle. The item that completes a calibration adds a deviation pass, which streams
// the calibration memory through the same multiplier one entry a cycle, a square root that runs
// one bit pair a cycle, and then scaling by k and the threshold update. A stalled output holds
// the sequencer in its last state for as long as the stall lasts.
// A finished result waits in the output register while the next item is already being worked.
`default_nettype none
module tke_onset_detector_top (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      s_tvalid,
  output logic                     s_tready,
  input  wire  [15:0]              s_tdata,   // sample[11:0], start_calibration[12], zero pad
  output logic                     m_tvalid,
  input  wire                      m_tready,
  output logic [95:0]              m_tdata,   // energy[27:0], window_mean[55:28],
                                              // detect_state[57:56], calibrated[58],
                                              // threshold_out[90:59], zero pad
  output logic                     m_tuser,   // mean_valid
  input  wire                      cfg_we,
  input  wire                      cfg_index,
  input  wire  [tke_pkg::CFG_W-1:0] cfg_data
);
  import tke_pkg::*;

  state_t state, state_next;

  logic [K_W-1:0]    k_threshold;
  logic [HOLD_W-1:0] holdoff_length;

  logic signed [SCALED_W-1:0] prev_a, prev_b, c_reg;
  logic                       start_r;
  logic signed [PROD_W-1:0]   prod, bb_reg, mul_res;
  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic [ENERGY_W-1:0]        energy_r;

  logic [ENERGY_W-1:0] ring_mem [WINDOW_LEN];
  logic [ENERGY_W-1:0] ring_rdata;
  logic [RPTR_W-1:0]   ring_pointer;
  logic                ring_wrapped;
  logic [FILL_W-1:0]   fill_count;
  logic [WSUM_W-1:0]   window_sum;
  logic [ENERGY_W-1:0] mean_reg;
  logic                mean_vld;

  logic [ENERGY_W-1:0] calib_mem [CALIB_LEN];
  logic [ENERGY_W-1:0] calib_rdata;
  logic [CIDX_W-1:0]   calib_index, calib_raddr;
  logic                calib_active, calibrated_flag;
  logic [CSUM_W-1:0]   calib_sum;
  logic [ENERGY_W-1:0] mean_cal;
  logic [CIDX_W:0]     sq_cnt;
  logic                rd_vld, prod_vld;
  logic [SQ_W-1:0]     sq_acc;
  logic [VAR_W-1:0]    sq_v, sq_res, sq_bit;

  logic [THR_W-1:0]  threshold_reg;
  logic [1:0]        detect_reg;
  logic [HOLD_W-1:0] holdoff_count;

  // combinational helpers
  logic signed [PROD_W-1:0] e_diff;
  logic [ENERGY_W-1:0]      energy_abs, ring_old, dev;
  logic [WSUM_W-1:0]        wsum_new;
  logic [FILL_W-1:0]        fill_inc;
  logic                     cal_act;
  logic [CIDX_W-1:0]        cal_idx;
  logic [CSUM_W-1:0]        csum_new;
  logic                     sq_issue, sq_take;
  logic [VAR_W-1:0]         sq_trial;
  logic [THR_W:0]           thr_sum;
  logic [HOLD_W-1:0]        hold_n;
  logic [1:0]               det_n;
  logic                     above;
  logic                     out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  assign e_diff     = bb_reg - prod;
  assign energy_abs = e_diff[PROD_W-1] ? ENERGY_W'(-e_diff) : e_diff[ENERGY_W-1:0];
  assign ring_old   = ring_wrapped ? ring_rdata : '0;
  assign wsum_new   = window_sum - WSUM_W'(ring_old) + WSUM_W'(energy_r);
  assign fill_inc   = fill_count + FILL_W'(1);
  assign cal_act    = calib_active || start_r;
  assign cal_idx    = start_r ? '0 : calib_index;
  assign csum_new   = (start_r ? '0 : calib_sum) + CSUM_W'(energy_r);
  assign dev        = (calib_rdata >= mean_cal) ? calib_rdata - mean_cal : mean_cal - calib_rdata;
  assign sq_issue   = !sq_cnt[CIDX_W];
  assign sq_trial   = sq_res + sq_bit;
  assign sq_take    = sq_v >= sq_trial;
  assign thr_sum    = (THR_W+1)'(mean_cal) + (THR_W+1)'(prod[PROD_W-1:4]);
  assign above      = {{(THR_W-ENERGY_W){1'b0}}, mean_reg} >= threshold_reg;
  assign calib_raddr = sq_cnt[CIDX_W-1:0];

  // shared multiplier
  always_comb begin
    unique case (state)
      S_MBB: begin
        mul_a = MUL_W'(prev_b);
        mul_b = MUL_W'(prev_b);
      end
      S_MAC: begin
        mul_a = MUL_W'(prev_a);
        mul_b = MUL_W'(c_reg);
      end
      S_SQ: begin
        mul_a = {1'b0, dev};
        mul_b = {1'b0, dev};
      end
      S_KMUL: begin
        mul_a = {{(MUL_W-K_W){1'b0}}, k_threshold};
        mul_b = {1'b0, sq_res[ENERGY_W-1:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_res = mul_a * mul_b;

  // onset detection on a new mean
  always_comb begin
    hold_n = holdoff_count;
    det_n  = detect_reg;
    if (holdoff_count != '0) hold_n = holdoff_count + HOLD_W'(1);
    if (hold_n == holdoff_length) hold_n = '0;
    if (above && hold_n == '0) det_n = DET_ABOVE;
    if (!above) begin
      if (det_n == DET_ABOVE && hold_n == '0) begin
        det_n  = DET_RELEASE;
        hold_n = HOLD_W'(1);
      end else begin
        det_n = DET_QUIET;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (s_tvalid) state_next = S_MBB;
      S_MBB:    state_next = S_MAC;
      S_MAC:    state_next = S_ENERGY;
      S_ENERGY: state_next = S_UPDATE;
      S_UPDATE: state_next = (cal_act && cal_idx == CIDX_W'(CALIB_LEN - 1)) ? S_SQ : S_DETECT;
      S_SQ:     if (!sq_issue && !rd_vld && !prod_vld) state_next = S_SQRT;
      S_SQRT:   if (sq_bit == '0) state_next = S_KMUL;
      S_KMUL:   state_next = S_THR;
      S_THR:    state_next = S_DETECT;
      S_DETECT: state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    ring_rdata <= ring_mem[ring_pointer];
    if (state == S_UPDATE) ring_mem[ring_pointer] <= energy_r;
  end

  always_ff @(posedge clk) begin
    calib_rdata <= calib_mem[calib_raddr];
    if (state == S_UPDATE && cal_act) calib_mem[cal_idx] <= energy_r;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      k_threshold    <= K_W'(48);
      holdoff_length <= HOLD_W'(10);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_K_THRESHOLD: k_threshold    <= cfg_data[K_W-1:0];
        REG_HOLDOFF:     holdoff_length <= cfg_data[HOLD_W-1:0];
        default:         ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prod <= mul_res;
    unique case (state)
      S_IDLE: begin
        c_reg   <= (SCALED_W'($signed(s_tdata[SAMPLE_W-1:0])) <<< 2)
                   + SCALED_W'($signed(s_tdata[SAMPLE_W-1:0]));
        start_r <= s_tdata[SAMPLE_W];
      end
      S_MAC:    bb_reg <= prod;
      S_ENERGY: energy_r <= energy_abs;
      S_UPDATE: begin
        calib_sum <= csum_new;
        mean_cal  <= csum_new[CSUM_W-1:CIDX_W];
        sq_acc    <= '0;
      end
      S_SQ: if (prod_vld) sq_acc <= sq_acc + SQ_W'(prod[VAR_W-1:0]);
      default: ;
    endcase
    if (state == S_SQ && state_next == S_SQRT) begin
      sq_v   <= sq_acc[SQ_W-1:CIDX_W];
      sq_res <= '0;
      sq_bit <= VAR_W'(1) << (VAR_W - 2);
    end else if (state == S_SQRT && sq_bit != '0) begin
      if (sq_take) begin
        sq_v   <= sq_v - sq_trial;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_a          <= '0;
      prev_b          <= '0;
      ring_pointer    <= '0;
      ring_wrapped    <= 1'b0;
      fill_count      <= '0;
      window_sum      <= '0;
      mean_reg        <= '0;
      mean_vld        <= 1'b0;
      calib_index     <= '0;
      calib_active    <= 1'b0;
      calibrated_flag <= 1'b0;
      threshold_reg   <= '0;
      detect_reg      <= DET_QUIET;
      holdoff_count   <= '0;
      sq_cnt          <= '0;
      rd_vld          <= 1'b0;
      prod_vld        <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      unique case (state)
        S_ENERGY: begin
          prev_a <= prev_b;
          prev_b <= c_reg;
        end
        S_UPDATE: begin
          window_sum   <= wsum_new;
          ring_pointer <= ring_pointer + RPTR_W'(1);
          if (ring_pointer == RPTR_W'(WINDOW_LEN - 1)) ring_wrapped <= 1'b1;
          if (fill_inc >= FILL_W'(WINDOW_LEN)) begin
            mean_reg   <= wsum_new[WSUM_W-1:RPTR_W];
            fill_count <= FILL_W'(EFF_OVERLAP);
            mean_vld   <= 1'b1;
          end else begin
            fill_count <= fill_inc;
            mean_vld   <= 1'b0;
          end
          if (cal_act) begin
            calib_index  <= cal_idx + CIDX_W'(1);
            calib_active <= (cal_idx != CIDX_W'(CALIB_LEN - 1));
          end
          sq_cnt   <= '0;
          rd_vld   <= 1'b0;
          prod_vld <= 1'b0;
        end
        S_SQ: begin
          if (sq_issue) sq_cnt <= sq_cnt + (CIDX_W+1)'(1);
          rd_vld   <= sq_issue;
          prod_vld <= rd_vld;
        end
        S_THR: begin
          threshold_reg   <= thr_sum[THR_W] ? '1 : thr_sum[THR_W-1:0];
          calibrated_flag <= 1'b1;
        end
        S_DETECT: begin
          if (mean_vld) begin
            detect_reg    <= det_n;
            holdoff_count <= hold_n;
          end
        end
        default: ;
      endcase
      if (state == S_DONE && out_free) m_tvalid <= 1'b1;
      else if (m_tready)               m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tdata <= {5'd0, threshold_reg, calibrated_flag, detect_reg, mean_reg, energy_r};
      m_tuser <= mean_vld;
    end
  end

  // checks
  a_cal_sticky: assert property (@(posedge clk) disable iff (rst) !$fell(calibrated_flag))
    else $error("calibrated flag dropped");
  a_det_code: assert property (@(posedge clk) disable iff (rst) detect_reg != 2'd3)
    else $error("detect state out of range");
  a_thr_cal: assert property (@(posedge clk) disable iff (rst)
                              threshold_reg != '0 |-> calibrated_flag)
    else $error("threshold set without calibration");
  a_fill: assert property (@(posedge clk) disable iff (rst)
                           s_tready |-> fill_count < FILL_W'(WINDOW_LEN))
    else $error("window fill count overran");
endmodule
`default_nettype wire
